// ===== rtl/core/dssm_pkg.sv =====
// Shared types and constants for the diagonal state-space recurrence block.
// Depends on nothing; imported by the controller, datapath, top level and testbench.
package dssm_pkg;

  localparam int DATA_W    = 16;
  localparam int FRAC_BITS = 12;

  typedef enum logic [1:0] {
    FUNC_STEP  = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RUN,
    S_DRAIN
  } state_e;

  typedef struct packed {
    logic [1:0]               func;
    logic [3:0]               channel;
    logic [3:0]               state_index;
    logic signed [DATA_W-1:0] a_real_in;
    logic signed [DATA_W-1:0] a_imag_in;
    logic signed [DATA_W-1:0] c_real_in;
    logic signed [DATA_W-1:0] c_imag_in;
    logic signed [DATA_W-1:0] u_sample;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] y_out;
    logic [3:0]               out_channel;
  } out_rsp_t;

  typedef struct packed {
    logic step_start;
    logic load_we;
    logic clr_we;
    logic issue;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/dssm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Standalone; used for the state and coefficient stores.
module dssm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/dssm_ctrl.sv =====
// Controller state machine: request decode, state sweep, element sequencing.
// Depends on dssm_pkg; drives the datapath through dp_cmd_t.
module dssm_ctrl import dssm_pkg::*; #(
  parameter int NUM_CHANNELS = 16,
  parameter int NUM_STATES   = 16,
  parameter int AW           = 8,
  parameter int NW           = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  in_req_t       in_req_i,
  output logic          in_ready_o,
  output dp_cmd_t       cmd_o,
  output logic [NW-1:0] idx_o,
  output logic [AW-1:0] clr_addr_o,
  input  dp_stat_t      stat_i
);

  localparam int DEPTH = NUM_CHANNELS * NUM_STATES;

  state_e        state_q, state_d;
  logic [NW-1:0] idx_q, idx_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          accept, ch_ok, si_ok;
  logic          is_step, is_load, is_clear;

  assign accept   = in_valid_i && in_ready_o;
  assign ch_ok    = 32'(in_req_i.channel) < NUM_CHANNELS;
  assign si_ok    = 32'(in_req_i.state_index) < NUM_STATES;
  assign is_step  = in_req_i.func == FUNC_STEP;
  assign is_load  = in_req_i.func == FUNC_LOAD;
  assign is_clear = in_req_i.func == FUNC_CLEAR;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == AW'(DEPTH - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept && is_step && ch_ok) begin
          state_d = S_RUN;
        end else if (accept && is_clear) begin
          state_d = S_CLEAR;
        end
      end
      S_RUN: begin
        if (idx_q == NW'(NUM_STATES - 1)) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (!stat_i.busy && stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    case (state_q)
      S_CLEAR: cmd_o.clr_we = 1'b1;
      S_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.step_start = in_valid_i && is_step && ch_ok;
        cmd_o.load_we    = in_valid_i && is_load && ch_ok && si_ok;
      end
      S_RUN: cmd_o.issue = 1'b1;
      S_DRAIN: cmd_o.out_load = !stat_i.busy && stat_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  assign idx_d      = (state_q == S_RUN) ? idx_q + 1'b1 : '0;
  assign clr_d      = (state_q == S_CLEAR) ? clr_q + 1'b1 : '0;
  assign idx_o      = idx_q;
  assign clr_addr_o = clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      idx_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      clr_q   <= clr_d;
    end
  end

`ifndef SYNTHESIS
  // The pipeline must be empty whenever a new request can be taken.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !stat_i.busy)
    else $error("datapath busy while idle");

  // A result is only captured once every element has been accumulated.
  a_load_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!stat_i.busy && stat_i.out_free))
    else $error("result captured early or over a pending one");

  // An accepted step starts its walk at element zero.
  a_step_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_step && ch_ok) |=> (state_q == S_RUN && idx_q == '0))
    else $error("step did not start at element zero");

  // Issue commands occur only during the element walk.
  a_issue_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.issue |-> ($past(state_q) == S_IDLE || $past(state_q) == S_RUN))
    else $error("element issued outside a step");
`endif

endmodule

// ===== rtl/core/dssm_datapath.sv =====
// Datapath: state and coefficient stores, complex multiply pipeline,
// accumulator and output register. Depends on dssm_pkg and dssm_ram.
module dssm_datapath import dssm_pkg::*; #(
  parameter int NUM_CHANNELS = 16,
  parameter int NUM_STATES   = 16,
  parameter int AW           = 8,
  parameter int NW           = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  in_req_t       in_req_i,
  input  dp_cmd_t       cmd_i,
  input  logic [NW-1:0] idx_i,
  input  logic [AW-1:0] clr_addr_i,
  output dp_stat_t      stat_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output out_rsp_t      out_rsp_o
);

  localparam int DEPTH = NUM_CHANNELS * NUM_STATES;
  localparam int PW    = 2 * DATA_W;
  localparam int HI    = FRAC_BITS + DATA_W - 1;

  logic [3:0]               ch_q;
  logic signed [DATA_W-1:0] u_q;

  logic [AW-1:0] rd_addr, ld_addr;
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [PW-1:0] st_wdata, st_rdata;
  logic [2*PW-1:0] cf_wdata, cf_rdata;

  logic signed [DATA_W-1:0] sr, si, ar, ai, cr, ci;

  // Pipeline stage registers.
  logic          v1_q, v2_q, v3_q, v4_q;
  logic [AW-1:0] a1_q, a2_q, a3_q;
  logic signed [PW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [DATA_W-1:0] cr2_q, ci2_q, cr3_q, ci3_q;
  logic signed [DATA_W-1:0] nr3_q, ni3_q;
  logic signed [PW-1:0] q_r4_q, q_i4_q;
  logic [PW-1:0] re_sum, im_sum, y_sum;
  logic [DATA_W-1:0] nr_d, ni_d;
  logic [DATA_W-1:0] acc_q;

  logic          out_valid_q;
  out_rsp_t      out_rsp_q;

  assign rd_addr = AW'(32'(ch_q) * NUM_STATES + 32'(idx_i));
  assign ld_addr = AW'(32'(in_req_i.channel) * NUM_STATES + 32'(in_req_i.state_index));

  assign st_we    = cmd_i.clr_we || v3_q;
  assign st_waddr = cmd_i.clr_we ? clr_addr_i : a3_q;
  assign st_wdata = cmd_i.clr_we ? '0 : {nr3_q, ni3_q};
  assign cf_wdata = {in_req_i.a_real_in, in_req_i.a_imag_in,
                     in_req_i.c_real_in, in_req_i.c_imag_in};

  dssm_ram #(.WIDTH(PW), .DEPTH(DEPTH)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (rd_addr),
    .rdata_o (st_rdata)
  );

  dssm_ram #(.WIDTH(2 * PW), .DEPTH(DEPTH)) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_we),
    .waddr_i (ld_addr),
    .wdata_i (cf_wdata),
    .raddr_i (rd_addr),
    .rdata_o (cf_rdata)
  );

  assign sr = $signed(st_rdata[PW-1:DATA_W]);
  assign si = $signed(st_rdata[DATA_W-1:0]);
  assign ar = $signed(cf_rdata[4*DATA_W-1:3*DATA_W]);
  assign ai = $signed(cf_rdata[3*DATA_W-1:2*DATA_W]);
  assign cr = $signed(cf_rdata[2*DATA_W-1:DATA_W]);
  assign ci = $signed(cf_rdata[DATA_W-1:0]);

  // Only bits up to HI of each sum matter after the shift and wrap.
  assign re_sum = p_rr_q - p_ii_q;
  assign im_sum = p_ri_q + p_ir_q;
  assign nr_d   = re_sum[HI:FRAC_BITS] + u_q;
  assign ni_d   = im_sum[HI:FRAC_BITS];
  assign y_sum  = q_r4_q - q_i4_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_start) begin
      ch_q <= in_req_i.channel;
      u_q  <= in_req_i.u_sample;
    end
    a1_q   <= rd_addr;
    p_rr_q <= PW'(ar) * PW'(sr);
    p_ii_q <= PW'(ai) * PW'(si);
    p_ri_q <= PW'(ar) * PW'(si);
    p_ir_q <= PW'(ai) * PW'(sr);
    cr2_q  <= cr;
    ci2_q  <= ci;
    a2_q   <= a1_q;
    nr3_q  <= $signed(nr_d);
    ni3_q  <= $signed(ni_d);
    cr3_q  <= cr2_q;
    ci3_q  <= ci2_q;
    a3_q   <= a2_q;
    q_r4_q <= PW'(cr3_q) * PW'(nr3_q);
    q_i4_q <= PW'(ci3_q) * PW'(ni3_q);
    if (cmd_i.out_load) begin
      out_rsp_q.y_out       <= $signed(acc_q);
      out_rsp_q.out_channel <= ch_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (cmd_i.step_start) begin
        acc_q <= '0;
      end else if (v4_q) begin
        acc_q <= acc_q + y_sum[HI:FRAC_BITS];
      end
      out_valid_q <= cmd_i.out_load || (out_valid_q && !out_ready_i);
    end
  end

  assign stat_o.busy     = v1_q || v2_q || v3_q || v4_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_rsp_o       = out_rsp_q;

endmodule

// ===== rtl/core/diagonal_ssm_recurrence_step.sv =====
// Top level of the diagonal complex state-space recurrence bank.
// Depends on dssm_pkg, dssm_ctrl, dssm_datapath and dssm_ram.
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+-----------------------
//   in      | input     | in_valid_i / in_ready_o   | in_req_i  (in_req_t)
//   out     | output    | out_valid_o / out_ready_i | out_rsp_o (out_rsp_t)
//
// A step request is taken in the idle state; one state element enters the
// multiply pipeline per cycle, and the four-stage pipeline behind the
// registered store reads must drain and the result be registered before
// the next request is taken. Load requests leave the block idle and ready.
// After reset, and for every clear request, the state store is swept one
// entry per cycle over all NUM_CHANNELS * NUM_STATES entries, with no
// request taken.
// A pending result does not hold back loads or clears; a finished step
// waits in its drain state until the output register is free.
module diagonal_ssm_recurrence_step import dssm_pkg::*; #(
  parameter int NUM_CHANNELS = 16,
  parameter int NUM_STATES   = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_rsp_o
);

  // The state and coefficient stores are addressed by channel * NUM_STATES
  // plus the element index, so their depth is the product of the two.
  localparam int DEPTH = NUM_CHANNELS * NUM_STATES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [NW-1:0] idx;
  logic [AW-1:0] clr_addr;

  // The controller decodes each request, walks the element index of a step
  // and sweeps the state store on reset and on clear requests.
  dssm_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_STATES   (NUM_STATES),
    .AW           (AW),
    .NW           (NW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .idx_o      (idx),
    .clr_addr_o (clr_addr),
    .stat_i     (stat)
  );

  // The datapath holds the stores, the complex multiply pipeline, the
  // accumulator and the output register that parts the two channels.
  dssm_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .NUM_STATES   (NUM_STATES),
    .AW           (AW),
    .NW           (NW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cmd_i       (cmd),
    .idx_i       (idx),
    .clr_addr_i  (clr_addr),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench for diagonal_ssm_recurrence_step: load, clear and step requests checked
// against a Q4.12 predictor held in this file. Depends on dssm_pkg and the block's RTL.
module tb;
  import dssm_pkg::*;

  localparam int NUM_CH      = 16;
  localparam int NUM_ST      = 16;
  localparam int MEM_DEPTH   = NUM_CH * NUM_ST;
  localparam int MAX_REPORTS = 10;
  // This margin covers any result still in flight.
  localparam int DRAIN_CYCLES = NUM_ST + 12;
  // Several times the slowest correct run, in nanoseconds.
  localparam int TIMEOUT_NS  = 3_000_000;

  // The spare function code, which the block must ignore.
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  localparam logic signed [DATA_W-1:0] Q_MAX = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] Q_MIN = 16'sh8000;
  localparam logic signed [DATA_W-1:0] Q_ONE = 16'sh1000;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  in_req_t  in_req_i;
  logic     out_valid_o;
  logic     out_ready_i;
  out_rsp_t out_rsp_o;

  diagonal_ssm_recurrence_step #(
    .NUM_CHANNELS(NUM_CH),
    .NUM_STATES  (NUM_ST)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Shadow copy of the block's stores. The state parts are updated as each step request is
  // accepted; the coefficient stores follow the load requests.
  logic signed [DATA_W-1:0] state_re  [MEM_DEPTH];
  logic signed [DATA_W-1:0] state_im  [MEM_DEPTH];
  logic signed [DATA_W-1:0] a_coef_re [MEM_DEPTH];
  logic signed [DATA_W-1:0] a_coef_im [MEM_DEPTH];
  logic signed [DATA_W-1:0] c_coef_re [MEM_DEPTH];
  logic signed [DATA_W-1:0] c_coef_im [MEM_DEPTH];

  // One bit per coefficient entry that has been written. A channel may only be stepped once all
  // of its entries are written, since an unwritten coefficient holds no defined value.
  logic [NUM_ST-1:0] coef_written [NUM_CH];

  out_rsp_t pending_y_q[$];
  int       mismatch_cnt;
  int       send_idle_pct;
  int       recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS * 1ns);
    $display("tb: failure");
    $finish;
  end

  // The receiver decides at each falling edge whether to stall on the following rising edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) begin
      $display("tb: mismatch at %0t: %s", $realtime, msg);
    end
  endfunction

  // Every result taken at a rising edge is compared with the oldest step still waiting.
  always @(posedge clk_i) begin : check_result
    out_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_y_q.size() == 0) begin
        note_mismatch($sformatf("result with no step waiting: y_out %0d, channel %0d",
                                out_rsp_o.y_out, out_rsp_o.out_channel));
      end else begin
        want = pending_y_q.pop_front();
        if (out_rsp_o.y_out !== want.y_out) begin
          note_mismatch($sformatf("y_out expected %0d, got %0d (channel %0d)",
                                  want.y_out, out_rsp_o.y_out, want.out_channel));
        end
        if (out_rsp_o.out_channel !== want.out_channel) begin
          note_mismatch($sformatf("out_channel expected %0d, got %0d",
                                  want.out_channel, out_rsp_o.out_channel));
        end
      end
    end
  end

  // Walks every state element of one channel: the complex state is rotated and scaled by A,
  // the sample is added to the real part, and Re(C * s') is summed in 32 bits.
  function automatic out_rsp_t predict_step(input logic [3:0] ch,
                                            input logic signed [DATA_W-1:0] u);
    longint                   ar, ai, cr, ci, sr, si, prod;
    logic signed [DATA_W-1:0] nr, ni;
    logic [31:0]              acc;
    int                       idx;
    int                       n;
    out_rsp_t                 rsp;
    acc = '0;
    for (n = 0; n < NUM_ST; n++) begin
      idx  = ch * NUM_ST + n;
      ar   = a_coef_re[idx];
      ai   = a_coef_im[idx];
      cr   = c_coef_re[idx];
      ci   = c_coef_im[idx];
      sr   = state_re[idx];
      si   = state_im[idx];
      // The products are exact in 64 bits; the shift floors, then the part wraps to 16 bits.
      prod = (ar * sr - ai * si) >>> FRAC_BITS;
      nr   = prod[DATA_W-1:0];
      prod = (ar * si + ai * sr) >>> FRAC_BITS;
      ni   = prod[DATA_W-1:0];
      nr   = nr + u;
      state_re[idx] = nr;
      state_im[idx] = ni;
      prod = (cr * longint'(nr) - ci * longint'(ni)) >>> FRAC_BITS;
      acc  = acc + prod[31:0];
    end
    rsp.y_out       = acc[DATA_W-1:0];
    rsp.out_channel = ch;
    return rsp;
  endfunction

  // Brings the shadow stores up to date with an accepted request. The 4-bit channel and state
  // index fields cannot leave the 16 x 16 bank, so no range check is needed here.
  function automatic void track_request(input in_req_t req);
    int idx;
    int k;
    idx = req.channel * NUM_ST + req.state_index;
    case (req.func)
      FUNC_STEP: begin
        pending_y_q.push_back(predict_step(req.channel, req.u_sample));
      end
      FUNC_LOAD: begin
        a_coef_re[idx] = req.a_real_in;
        a_coef_im[idx] = req.a_imag_in;
        c_coef_re[idx] = req.c_real_in;
        c_coef_im[idx] = req.c_imag_in;
        coef_written[req.channel][req.state_index] = 1'b1;
      end
      FUNC_CLEAR: begin
        // Only the state goes back to zero; the coefficients survive a clear.
        for (k = 0; k < MEM_DEPTH; k++) begin
          state_re[k] = '0;
          state_im[k] = '0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Presents one request at a falling edge, after a random idle gap, and holds it until the
  // block takes it. The request stays on the bus until the next falling edge, where the next
  // call either replaces it or the gap lowers valid.
  task automatic send_req(input in_req_t req);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    track_request(req);
  endtask

  task automatic wait_results_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_y_q.size() != 0) @(posedge clk_i);
  endtask

  // Fields that a function code does not use still carry random bits.
  function automatic in_req_t rand_req(input logic [1:0] fn);
    in_req_t req;
    req.func        = fn;
    req.channel     = 4'($urandom);
    req.state_index = 4'($urandom);
    req.a_real_in   = 16'($urandom);
    req.a_imag_in   = 16'($urandom);
    req.c_real_in   = 16'($urandom);
    req.c_imag_in   = 16'($urandom);
    req.u_sample    = 16'($urandom);
    return req;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_extreme();
    case ($urandom_range(5))
      0:       return Q_MAX;
      1:       return Q_MIN;
      2:       return Q_ONE;
      3:       return -Q_ONE;
      4:       return '0;
      default: return -16'sd1;
    endcase
  endfunction

  // Coefficients of magnitude up to one in four draws out of ten, so that state survives
  // several steps, with full-range values and the extremes making up the rest.
  function automatic logic signed [DATA_W-1:0] rand_coef();
    int v;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        v = int'($urandom_range(8192)) - 4096;
        return v[DATA_W-1:0];
      end
      4, 5, 6: return 16'($urandom);
      default: return pick_extreme();
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_sample();
    int v;
    case ($urandom_range(19))
      0, 1, 2, 3, 4: begin
        v = int'($urandom_range(2048)) - 1024;
        return v[DATA_W-1:0];
      end
      5, 6, 7: return pick_extreme();
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load_entry(input logic [3:0] ch, input logic [3:0] si,
                            input logic signed [DATA_W-1:0] ar,
                            input logic signed [DATA_W-1:0] ai,
                            input logic signed [DATA_W-1:0] cr,
                            input logic signed [DATA_W-1:0] ci);
    in_req_t req;
    req             = rand_req(FUNC_LOAD);
    req.channel     = ch;
    req.state_index = si;
    req.a_real_in   = ar;
    req.a_imag_in   = ai;
    req.c_real_in   = cr;
    req.c_imag_in   = ci;
    send_req(req);
  endtask

  task automatic load_channel_rand(input logic [3:0] ch);
    int si;
    for (si = 0; si < NUM_ST; si++) begin
      load_entry(ch, 4'(si), rand_coef(), rand_coef(), rand_coef(), rand_coef());
    end
  endtask

  task automatic step_channel(input logic [3:0] ch, input logic signed [DATA_W-1:0] u);
    in_req_t req;
    req          = rand_req(FUNC_STEP);
    req.channel  = ch;
    req.u_sample = u;
    send_req(req);
  endtask

  // Returns a channel whose coefficients are all written, or -1 if there is none yet.
  function automatic int pick_loaded_channel();
    int usable_q[$];
    int c;
    for (c = 0; c < NUM_CH; c++) begin
      if (&coef_written[c]) usable_q.push_back(c);
    end
    if (usable_q.size() == 0) return -1;
    return usable_q[$urandom_range(usable_q.size() - 1)];
  endfunction

  // Hand-picked cases: the spare code with every field bit set, identity coefficients where
  // each output is NUM_ST times the running sum of samples, the most negative and most positive
  // values everywhere so that the state wraps, a clear that keeps the coefficients, and a
  // zero coefficient in the last state element.
  task automatic test_directed();
    in_req_t req;
    int      si;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    req            = '1;
    send_req(req);
    for (si = 0; si < NUM_ST; si++) begin
      load_entry(4'd0, 4'(si), Q_ONE, '0, Q_ONE, '0);
    end
    step_channel(4'd0, 16'sd1);
    step_channel(4'd0, 16'sd1);
    step_channel(4'd0, Q_MAX);
    step_channel(4'd0, Q_MIN);
    for (si = 0; si < NUM_ST; si++) begin
      load_entry(4'd15, 4'(si), si[0] ? Q_MAX : Q_MIN, si[0] ? Q_MIN : Q_MAX,
                 si[1] ? Q_MAX : Q_MIN, si[1] ? Q_MIN : Q_MAX);
    end
    step_channel(4'd15, Q_MAX);
    step_channel(4'd15, Q_MIN);
    step_channel(4'd15, '0);
    send_req(rand_req(FUNC_CLEAR));
    step_channel(4'd0, '0);
    step_channel(4'd15, -16'sd1);
    load_entry(4'd0, 4'd15, '0, '0, '0, '0);
    step_channel(4'd0, 16'sd100);
    req         = rand_req(FUNC_SPARE);
    req.channel = 4'd0;
    send_req(req);
    step_channel(4'd0, Q_MAX);
  endtask

  // The sender holds off until every step has produced its result, then carries on at once.
  task automatic test_pause_until_drained();
    int k;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (k = 0; k < 8; k++) begin
      step_channel(k[0] ? 4'd15 : 4'd0, rand_sample());
    end
    wait_results_drained();
    for (k = 0; k < 8; k++) begin
      step_channel(k[0] ? 4'd0 : 4'd15, rand_sample());
    end
    wait_results_drained();
  endtask

  // Mostly bursts of steps on fully loaded channels, with whole-channel and single-entry
  // reloads, the odd clear, and spare codes as noise that do not count towards the total.
  task automatic test_random_traffic(input int n_items, input int idle_pct, input int stall_pct);
    int count;
    int pick;
    int ch;
    int burst;
    int k;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    count          = 0;
    while (count < n_items) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_req(rand_req(FUNC_CLEAR));
        count++;
      end else if (pick < 6) begin
        send_req(rand_req(FUNC_SPARE));
      end else if (pick < 20) begin
        send_req(rand_req(FUNC_LOAD));
        count++;
      end else if (pick < 23) begin
        load_channel_rand(4'($urandom));
        count += NUM_ST;
      end else begin
        ch = pick_loaded_channel();
        if (ch < 0) begin
          load_channel_rand(4'($urandom));
          count += NUM_ST;
        end else begin
          burst = $urandom_range(1, 6);
          for (k = 0; k < burst; k++) begin
            step_channel(4'(ch), rand_sample());
          end
          count += burst;
        end
      end
    end
    wait_results_drained();
  endtask

  initial begin : run_tests
    int c;
    int k;
    in_valid_i     = 1'b0;
    in_req_i       = '0;
    out_ready_i    = 1'b0;
    rst_ni         = 1'b0;
    mismatch_cnt   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (k = 0; k < MEM_DEPTH; k++) begin
      state_re[k]  = '0;
      state_im[k]  = '0;
      a_coef_re[k] = '0;
      a_coef_im[k] = '0;
      c_coef_re[k] = '0;
      c_coef_im[k] = '0;
    end
    for (c = 0; c < NUM_CH; c++) begin
      coef_written[c] = '0;
    end
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_pause_until_drained();
    test_random_traffic(400, 0, 0);
    test_random_traffic(400, 53, 0);
    test_random_traffic(400, 0, 53);
    test_random_traffic(400, 19, 19);

    // Anything arriving during this margin has no step behind it and is flagged as such.
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_y_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
